FILE: src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Sizes, command and status codes, channel words and the control and status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  // store depth and coordinate precision
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 32;
  localparam int MIN_VERTICES = 3;

  // fixed field widths of the channel words
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 9;

  // derived widths
  localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW    = CW + 1;
  localparam int LO_W  = (DW + 1) / 2;
  localparam int HI_W  = DW - LO_W;
  localparam int PW    = 2 * DW;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_VERTICES);

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } pip_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_FEW  = 2'd2
  } pip_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    PS_IDLE,
    PS_WALK,
    PS_DRAIN,
    PS_DONE
  } pip_state_e;

  // input word
  typedef struct packed {
    logic [1:0]                command;
    logic signed [FIELD_W-1:0] east;
    logic signed [FIELD_W-1:0] north;
  } pip_in_t;

  // output word
  typedef struct packed {
    logic               inside_res;
    logic [1:0]         status;
    logic [COUNT_W-1:0] vertex_count;
  } pip_out_t;

  // sequencer to datapath
  typedef struct packed {
    logic          wr_en;
    logic          rd_en;
    logic          first;
    logic          close;
    logic          start;
    logic [AW-1:0] addr;
  } pip_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic busy;
    logic enclosed;
  } pip_stat_t;

endpackage

FILE: src/pip_datapath.sv
// ----------------------------------------------------------------------------
// pip_datapath: vertex stores and edge crossing pipeline
// Holds both coordinate stores, walks one vertex per cycle into a five stage
// pipeline that forms edges, decides each ray crossing by an exact
// cross-multiplication compare and toggles the inside flag.
// ----------------------------------------------------------------------------
module pip_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pip_pkg::pip_in_t    in_i,
  input  pip_pkg::pip_ctl_t   ctl_i,
  output pip_pkg::pip_stat_t  stat_o
);
  import pip_pkg::*;

  logic signed [CW-1:0] in_e, in_n;
  logic [CW-1:0]        mem_e [MAX_VERTICES];
  logic [CW-1:0]        mem_n [MAX_VERTICES];
  logic signed [CW-1:0] rd_e_q, rd_n_q;
  logic signed [CW-1:0] pt_e_q, pt_n_q;
  logic signed [CW-1:0] prev_e_q, prev_n_q, first_e_q, first_n_q;
  logic signed [CW-1:0] cur_e, cur_n;

  logic v1_q, first1_q, close1_q;
  logic v2_q, v3_q, v4_q, v5_q;

  logic [DW-1:0] a_d, b_d, c_d, d_d;
  logic          strad_d;
  logic [DW-1:0] a2_q, b2_q, c2_q, d2_q;
  logic          strad2_q;

  logic [DW-1:0] ma3_q, mb3_q, mc3_q, md3_q;
  logic          ln3_q, rn3_q, dneg3_q, strad3_q;

  logic [2*LO_W-1:0]    ad_ll_q, bc_ll_q;
  logic [LO_W+HI_W-1:0] ad_lh_q, ad_hl_q, bc_lh_q, bc_hl_q;
  logic [2*HI_W-1:0]    ad_hh_q, bc_hh_q;
  logic                 ln4_q, rn4_q, dneg4_q, strad4_q;

  logic [PW-1:0] lm5_q, rm5_q;
  logic          ln5_q, rn5_q, dneg5_q, strad5_q;

  logic lt, gt, toggle;
  logic inside_q;

  assign in_e = in_i.east[CW-1:0];
  assign in_n = in_i.north[CW-1:0];

  // magnitude of a two's complement difference
  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    mag = x[DW-1] ? (~x + DW'(1)) : x;
  endfunction

  // coordinate stores, up to one write and one read a cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_e[ctl_i.addr] <= in_e;
      mem_n[ctl_i.addr] <= in_n;
    end
    if (ctl_i.rd_en) begin
      rd_e_q <= mem_e[ctl_i.addr];
      rd_n_q <= mem_n[ctl_i.addr];
    end
  end

  // test point
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      pt_e_q <= in_e;
      pt_n_q <= in_n;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      close1_q <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
    end else begin
      v1_q     <= ctl_i.rd_en | ctl_i.close;
      first1_q <= ctl_i.first;
      close1_q <= ctl_i.close;
      v2_q     <= v1_q & ~first1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
    end
  end

  // edge end: stored vertex, or the first one for the closing edge
  assign cur_e = close1_q ? first_e_q : rd_e_q;
  assign cur_n = close1_q ? first_n_q : rd_n_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prev_e_q <= cur_e;
      prev_n_q <= cur_n;
      if (first1_q) begin
        first_e_q <= cur_e;
        first_n_q <= cur_n;
      end
    end
  end

  // edge differences against the test point
  assign a_d = {pt_e_q[CW-1], pt_e_q} - {prev_e_q[CW-1], prev_e_q};
  assign b_d = {pt_n_q[CW-1], pt_n_q} - {prev_n_q[CW-1], prev_n_q};
  assign c_d = {cur_e[CW-1], cur_e} - {prev_e_q[CW-1], prev_e_q};
  assign d_d = {cur_n[CW-1], cur_n} - {prev_n_q[CW-1], prev_n_q};
  assign strad_d = (prev_n_q > pt_n_q) != (cur_n > pt_n_q);

  always_ff @(posedge clk_i) begin
    a2_q     <= a_d;
    b2_q     <= b_d;
    c2_q     <= c_d;
    d2_q     <= d_d;
    strad2_q <= strad_d;
  end

  // magnitudes and product signs, a zero product counts as positive
  always_ff @(posedge clk_i) begin
    ma3_q    <= mag(a2_q);
    mb3_q    <= mag(b2_q);
    mc3_q    <= mag(c2_q);
    md3_q    <= mag(d2_q);
    ln3_q    <= (a2_q[DW-1] ^ d2_q[DW-1]) & (|a2_q) & (|d2_q);
    rn3_q    <= (b2_q[DW-1] ^ c2_q[DW-1]) & (|b2_q) & (|c2_q);
    dneg3_q  <= d2_q[DW-1];
    strad3_q <= strad2_q;
  end

  // partial products of the split magnitudes
  always_ff @(posedge clk_i) begin
    ad_ll_q  <= ma3_q[LO_W-1:0] * md3_q[LO_W-1:0];
    ad_lh_q  <= ma3_q[LO_W-1:0] * md3_q[DW-1:LO_W];
    ad_hl_q  <= ma3_q[DW-1:LO_W] * md3_q[LO_W-1:0];
    ad_hh_q  <= ma3_q[DW-1:LO_W] * md3_q[DW-1:LO_W];
    bc_ll_q  <= mb3_q[LO_W-1:0] * mc3_q[LO_W-1:0];
    bc_lh_q  <= mb3_q[LO_W-1:0] * mc3_q[DW-1:LO_W];
    bc_hl_q  <= mb3_q[DW-1:LO_W] * mc3_q[LO_W-1:0];
    bc_hh_q  <= mb3_q[DW-1:LO_W] * mc3_q[DW-1:LO_W];
    ln4_q    <= ln3_q;
    rn4_q    <= rn3_q;
    dneg4_q  <= dneg3_q;
    strad4_q <= strad3_q;
  end

  // full product magnitudes
  always_ff @(posedge clk_i) begin
    lm5_q <= PW'(ad_ll_q) + (PW'(ad_lh_q) << LO_W) + (PW'(ad_hl_q) << LO_W)
           + (PW'(ad_hh_q) << (2 * LO_W));
    rm5_q <= PW'(bc_ll_q) + (PW'(bc_lh_q) << LO_W) + (PW'(bc_hl_q) << LO_W)
           + (PW'(bc_hh_q) << (2 * LO_W));
    ln5_q    <= ln4_q;
    rn5_q    <= rn4_q;
    dneg5_q  <= dneg4_q;
    strad5_q <= strad4_q;
  end

  // sign-magnitude compare of the two products
  always_comb begin
    if (ln5_q != rn5_q) begin
      lt = ln5_q;
      gt = rn5_q;
    end else if (ln5_q) begin
      lt = lm5_q > rm5_q;
      gt = lm5_q < rm5_q;
    end else begin
      lt = lm5_q < rm5_q;
      gt = lm5_q > rm5_q;
    end
  end

  assign toggle = v5_q & strad5_q & (dneg5_q ? gt : lt);

  // inside flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (ctl_i.start) begin
      inside_q <= 1'b0;
    end else if (toggle) begin
      inside_q <= ~inside_q;
    end
  end

  assign stat_o.busy     = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign stat_o.enclosed = inside_q;

endmodule

FILE: src/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl: command sequencer for the point-in-polygon test
// Decodes each input word, keeps the vertex count, walks the store for a
// point test, waits for the datapath to drain and hands the result over.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          command_i,
  output logic                in_stall_o,
  input  logic                out_free_i,
  input  pip_pkg::pip_stat_t  stat_i,
  output pip_pkg::pip_ctl_t   ctl_o,
  output logic                out_load_o,
  output pip_pkg::pip_out_t   res_o
);
  import pip_pkg::*;

  pip_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  pip_status_e       res_status_q, res_status_d;
  logic              res_test_q, res_test_d;

  // state and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= PS_IDLE;
      cnt_q        <= '0;
      idx_q        <= '0;
      res_status_q <= STS_OK;
      res_test_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      res_status_q <= res_status_d;
      res_test_q   <= res_test_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_test_d   = res_test_q;
    ctl_o        = '0;
    out_load_o   = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      PS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          res_status_d = STS_OK;
          res_test_d   = 1'b0;
          state_d      = PS_DONE;
          unique case (command_i)
            CMD_CLEAR: begin
              cnt_d = '0;
            end
            CMD_APPEND: begin
              if (cnt_q < CNT_MAX) begin
                ctl_o.wr_en = 1'b1;
                ctl_o.addr  = cnt_q[AW-1:0];
                cnt_d       = cnt_q + CNT_W'(1);
              end else begin
                res_status_d = STS_FULL;
              end
            end
            CMD_TEST: begin
              if (cnt_q < CNT_MIN) begin
                res_status_d = STS_FEW;
              end else begin
                ctl_o.start = 1'b1;
                res_test_d  = 1'b1;
                idx_d       = '0;
                state_d     = PS_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      PS_WALK: begin
        if (idx_q < cnt_q) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.addr  = idx_q[AW-1:0];
          ctl_o.first = (idx_q == '0);
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          ctl_o.close = 1'b1;
          state_d     = PS_DRAIN;
        end
      end
      PS_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = PS_DONE;
        end
      end
      PS_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = PS_IDLE;
        end
      end
      default: begin
        state_d = PS_IDLE;
      end
    endcase
  end

  // result word
  assign res_o.inside_res   = res_test_q & stat_i.enclosed;
  assign res_o.status       = res_status_q;
  assign res_o.vertex_count = COUNT_W'(cnt_q);

  // count stays within the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("vertex count above store depth");

  // walk reads only vertices that are held
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rd_en |-> (CNT_W'(ctl_o.addr) < cnt_q))
    else $error("walk read beyond held vertices");

  // polygon does not change under a running test
  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PS_WALK || state_q == PS_DRAIN) |=> $stable(cnt_q))
    else $error("vertex count changed during a test");

  // no store write while the walk uses the pipeline
  a_no_wr_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.wr_en |-> !(ctl_o.rd_en || ctl_o.close || stat_i.busy))
    else $error("store write during a walk");

  // a walked test only happens with enough vertices
  a_test_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o && res_test_q) |-> (cnt_q >= CNT_MIN))
    else $error("test result from too small a polygon");

endmodule

FILE: src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: ray crossing point-in-polygon test
// Usage:
//   Input channel in_valid_i / in_stall_o / in_i carries one word per
//   command: clear the polygon, append a vertex, or test a point.
//   Output channel out_valid_o / out_stall_i / out_o returns exactly one
//   word per accepted input: inside flag, status and vertex count.
//   Clear, append and unused commands pass from accept straight to the
//   result hand-over. A point test with n held vertices first walks the
//   stores, reading one vertex a cycle from their single read port, then
//   a five stage compare pipeline drains. One word is in work at once.
//   The input is stalled while a word is in work; a finished result sits in
//   the output register, so the next word is taken while it waits.
//   A stalled output holds its word; a new result waits in the sequencer
//   until the output register frees up.
//   Reset empties the polygon (count zero) and the output register; the
//   vertex stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pip_pkg::pip_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pip_pkg::pip_out_t out_o
);
  import pip_pkg::*;

  pip_ctl_t  ctl;
  pip_stat_t stat;
  pip_out_t  res;
  pip_out_t  out_q;
  logic      out_valid_q;
  logic      out_load;
  logic      out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // sequencer
  pip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_i.command),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .out_load_o (out_load),
    .res_o      (res)
  );

  // stores and crossing pipeline
  pip_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
